### hw/rtl/fbd_pkg.sv
// Shared types and constants of the flow burst detector.
package fbd_pkg;

	localparam int MAX_FLOWS_DEF = 1024;
	localparam int KEY_BITS_DEF  = 32;
	localparam int TIME_BITS_DEF = 48;

	localparam int CFG_ADDR_W = 6;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [2:0] {
		REG_GAP_LIMIT,
		REG_IDLE_TIMEOUT,
		REG_FLUSH_INTERVAL,
		REG_SMOOTHING_WEIGHT,
		REG_FLUSH_ENABLE,
		REG_TABLE_LIMIT
	} reg_idx_t;

	typedef enum logic [1:0] {
		OUT_UPDATED,
		OUT_NEW,
		OUT_RESTARTED,
		OUT_DROPPED
	} outcome_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [47:0] gap_limit;
		logic [47:0] idle_timeout;
		logic [47:0] flush_interval;
		logic [15:0] smoothing_weight;
		logic        flush_enable;
		logic [10:0] table_limit;
	} cfg_t;

endpackage

### hw/rtl/fbd_ram.sv
// Generic simple dual-port RAM with registered read.
module fbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/fbd_cfg.sv
// APB configuration registers of the flow burst detector.
module fbd_cfg #(
	parameter int TIME_BITS = fbd_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [fbd_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [fbd_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [fbd_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	output fbd_pkg::cfg_t                    cfg
);
	import fbd_pkg::*;

	localparam logic [63:0] TMASK64 = {64{1'b1}} >> (64 - TIME_BITS);
	localparam logic [47:0] TMASK   = TMASK64[47:0];

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[5:3]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_limit        <= 48'd5000000;
			cfg_q.idle_timeout     <= 48'd100000000;
			cfg_q.flush_interval   <= 48'd1000000;
			cfg_q.smoothing_weight <= 16'd58982;
			cfg_q.flush_enable     <= 1'b1;
			cfg_q.table_limit      <= 11'd1024;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_GAP_LIMIT:        cfg_q.gap_limit        <= pwdata[47:0] & TMASK;
				REG_IDLE_TIMEOUT:     cfg_q.idle_timeout     <= pwdata[47:0] & TMASK;
				REG_FLUSH_INTERVAL:   cfg_q.flush_interval   <= pwdata[47:0] & TMASK;
				REG_SMOOTHING_WEIGHT: cfg_q.smoothing_weight <= pwdata[15:0];
				REG_FLUSH_ENABLE:     cfg_q.flush_enable     <= pwdata[0];
				REG_TABLE_LIMIT:      cfg_q.table_limit      <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GAP_LIMIT:        prdata = {16'b0, cfg_q.gap_limit};
			REG_IDLE_TIMEOUT:     prdata = {16'b0, cfg_q.idle_timeout};
			REG_FLUSH_INTERVAL:   prdata = {16'b0, cfg_q.flush_interval};
			REG_SMOOTHING_WEIGHT: prdata = {48'b0, cfg_q.smoothing_weight};
			REG_FLUSH_ENABLE:     prdata = {63'b0, cfg_q.flush_enable};
			REG_TABLE_LIMIT:      prdata = {53'b0, cfg_q.table_limit};
			default:              prdata = '0;
		endcase
	end

endmodule

### hw/rtl/flow_burst_detector_ewma_unit.sv
// Top level of the EWMA flow burst detector with its flow table memory.
// One packet item at a time: after it is accepted the sequencer reads every
// entry of the flow table memory once, applying a due eviction sweep and
// looking for the key and a free slot on the way, then decides and, for an
// update, runs the EWMA in three steps (low product, high product, sum) and
// writes the entry back. The next packet is taken only after the result item
// of the last one has gone into the output register. After reset a clearing
// pass writes every entry once before the first item is taken; configuration
// writes are taken at any time. The result item sits in an output register,
// so the next packet is accepted while a result waits; a finished item holds
// off the next one only while the result before it is still unaccepted.
// Output tuser carries burst and outcome (0 updated, 1 new, 2 restarted,
// 3 dropped).
module flow_burst_detector_ewma_unit #(
	parameter int MAX_FLOWS = fbd_pkg::MAX_FLOWS_DEF,
	parameter int KEY_BITS  = fbd_pkg::KEY_BITS_DEF,
	parameter int TIME_BITS = fbd_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [79:0]                    s_tdata,   // flow_id[31:0], timestamp[79:32]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [79:0]                    m_tdata,   // report_flow[31:0], report_time[79:32]
	output logic [2:0]                     m_tuser,   // burst[0], outcome[2:1]
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fbd_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [fbd_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [fbd_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);
	import fbd_pkg::*;

	localparam int IW    = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
	localparam int CW    = $clog2(MAX_FLOWS + 1);
	localparam int SW    = TIME_BITS + 1;             // smoothed time, signed
	localparam int AW    = TIME_BITS + 3;             // arithmetic width, signed
	localparam int WW    = 2 + KEY_BITS + TIME_BITS + SW;
	localparam int SPLIT = AW / 2;
	localparam int HW    = AW - SPLIT;
	localparam int PW    = AW + 18;
	localparam int LAST_LO = SW;
	localparam int KEY_LO  = SW + TIME_BITS;
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_FLOWS - 1);

	// configuration
	cfg_t cfg;

	fbd_cfg #(.TIME_BITS(TIME_BITS)) u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg
	);

	logic signed [AW-1:0] lim_x, idle_x, flush_x;
	assign lim_x   = $signed(AW'({16'b0, cfg.gap_limit}));
	assign idle_x  = $signed(AW'({16'b0, cfg.idle_timeout}));
	assign flush_x = $signed(AW'({16'b0, cfg.flush_interval}));

	logic [16:0] m17;          // 65536 - weight
	assign m17 = 17'd65536 - {1'b0, cfg.smoothing_weight};

	// flow table memory: {valid, used, key, last_seen, smoothed}
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [WW-1:0] mem_wdata;
	logic [WW-1:0] mem_rdata;
	logic [IW:0]   cnt_q;

	fbd_ram #(.WIDTH(WW), .DEPTH(MAX_FLOWS)) u_table (
		.clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(cnt_q[IW-1:0]), .rdata(mem_rdata)
	);

	state_t state_q, state_d;

	logic                 rd_v_s1;
	logic [IW-1:0]        rd_idx_s1;
	logic [31:0]          fid_q;
	logic [47:0]          ts_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [TIME_BITS-1:0] t_q;
	logic                 sweep_q;
	logic [TIME_BITS-1:0] last_sweep_q;
	logic [CW-1:0]        occ_q;
	logic                 hit_q, free_q;
	logic [IW-1:0]        hit_idx_q, free_idx_q;
	logic [TIME_BITS-1:0] hit_last_q;
	logic signed [SW-1:0] hit_s_q;
	logic signed [AW-1:0] d_q, oldgap_q;
	logic [SPLIT+16:0]    plo_q;
	logic signed [HW+17:0] phi_q;
	logic signed [SW-1:0] snew_q;
	logic                 res_burst_q;
	outcome_t             res_outcome_q;
	logic                 m_tvalid_q;
	logic [79:0]          m_tdata_q;
	logic [2:0]           m_tuser_q;

	// input item
	logic                 accept;
	logic [63:0]          fid64, ts64;
	logic [KEY_BITS-1:0]  key_in;
	logic [TIME_BITS-1:0] t_in;
	logic                 sweep_due;

	assign accept   = s_tvalid && s_tready;
	assign fid64    = {32'b0, s_tdata[31:0]};
	assign ts64     = {16'b0, s_tdata[79:32]};
	assign key_in   = fid64[KEY_BITS-1:0];
	assign t_in     = ts64[TIME_BITS-1:0];
	assign sweep_due = ($signed({3'b000, t_in}) - $signed({3'b000, last_sweep_q})) > flush_x;

	logic signed [AW-1:0] t_x, hit_last_x, hit_s_x;
	assign t_x        = $signed({3'b000, t_q});
	assign hit_last_x = $signed({3'b000, hit_last_q});
	assign hit_s_x    = AW'(hit_s_q);

	// scan of one returned entry, with the sweep applied first
	logic                 r_valid, r_used, r_evict, n_valid, n_used, r_hit, r_free;
	logic [KEY_BITS-1:0]  r_key;
	logic [TIME_BITS-1:0] r_last;

	assign r_valid = mem_rdata[WW-1];
	assign r_used  = mem_rdata[WW-2];
	assign r_key   = mem_rdata[KEY_LO +: KEY_BITS];
	assign r_last  = mem_rdata[LAST_LO +: TIME_BITS];
	assign r_evict = sweep_q && r_valid &&
		(!r_used || ($signed({3'b000, r_last}) + idle_x < t_x));
	assign n_valid = r_valid && !r_evict;
	assign n_used  = sweep_q ? 1'b0 : r_used;
	assign r_hit   = rd_v_s1 && n_valid && !hit_q && (r_key == key_q);
	assign r_free  = rd_v_s1 && !n_valid && !free_q;

	// decision
	logic [16:0] lim17, cap17;
	logic        table_full, restart, burst_idle;
	logic signed [SW-1:0] s_restart;

	assign lim17      = {6'b0, cfg.table_limit};
	assign cap17      = (lim17 > 17'(MAX_FLOWS)) ? 17'(MAX_FLOWS) : lim17;
	assign table_full = (17'(occ_q) >= cap17) || !free_q;
	assign restart    = (hit_last_x + idle_x) < t_x;
	assign burst_idle = idle_x < lim_x;
	assign s_restart  = SW'(t_x - idle_x);

	// EWMA: s + floor(d * m / 65536), product in two partial products
	logic [SPLIT-1:0]      d_lo;
	logic signed [HW-1:0]  d_hi;
	logic [SPLIT+16:0]     plo_d;
	logic signed [HW+17:0] phi_d, d_hi_x, m_x;
	logic signed [PW-1:0]  prod_full, prod_shr;
	logic signed [AW-1:0]  snew_x, gap_new;
	logic                  burst_upd;

	assign d_lo   = d_q[SPLIT-1:0];
	assign d_hi   = d_q[AW-1:SPLIT];
	assign plo_d  = (SPLIT+17)'(d_lo) * (SPLIT+17)'(m17);
	assign d_hi_x = (HW+18)'(d_hi);
	assign m_x    = $signed((HW+18)'(m17));
	assign phi_d  = d_hi_x * m_x;
	assign prod_full = ($signed(PW'(phi_q)) <<< SPLIT) + $signed(PW'(plo_q));
	assign prod_shr  = prod_full >>> 16;
	assign snew_x    = hit_s_x + AW'(prod_shr);
	assign gap_new   = t_x - AW'(snew_q);
	assign burst_upd = (oldgap_q >= lim_x) && (gap_new < lim_x);

	logic out_load;
	assign out_load = (state_q == ST_FINISH) && (!m_tvalid_q || m_tready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (cnt_q[IW-1:0] == LAST_IDX) state_d = ST_IDLE;
			ST_IDLE:   if (accept) state_d = ST_SCAN;
			ST_SCAN:   if (rd_v_s1 && rd_idx_s1 == LAST_IDX) state_d = ST_DECIDE;
			ST_DECIDE: state_d = (hit_q && !restart) ? ST_MUL_LO : ST_FINISH;
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_SUM;
			ST_SUM:    state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_FINISH;
			ST_FINISH: if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory write port and handshake
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = hit_idx_q;
		mem_wdata = {1'b1, 1'b1, key_q, t_q, s_restart};
		s_tready  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[IW-1:0];
				mem_wdata = '0;
			end
			ST_IDLE: s_tready = 1'b1;
			ST_SCAN: begin
				mem_we    = rd_v_s1 && sweep_q && r_valid;
				mem_waddr = rd_idx_s1;
				mem_wdata = {n_valid, n_used, mem_rdata[WW-3:0]};
			end
			ST_DECIDE: begin
				if (!hit_q) begin
					mem_we    = !table_full;
					mem_waddr = free_idx_q;
				end else begin
					mem_we = restart;
				end
			end
			ST_UPDATE: begin
				mem_we    = 1'b1;
				mem_wdata = {1'b1, 1'b1, key_q, t_q, snew_q};
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			rd_v_s1      <= 1'b0;
			occ_q        <= '0;
			last_sweep_q <= '0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			sweep_q      <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= (state_q == ST_SCAN) && !cnt_q[IW] &&
				(cnt_q[IW-1:0] <= LAST_IDX) && !(rd_v_s1 && rd_idx_s1 == LAST_IDX);
			case (state_q)
				ST_CLEAR: cnt_q <= cnt_q + 1'b1;
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						sweep_q <= sweep_due && cfg.flush_enable;
						if (sweep_due) last_sweep_q <= t_in;
					end
				end
				ST_SCAN: begin
					if (cnt_q[IW-1:0] != LAST_IDX || !cnt_q[IW]) cnt_q <= cnt_q + 1'b1;
					if (rd_v_s1 && r_evict && occ_q != '0) occ_q <= occ_q - 1'b1;
					if (r_hit) hit_q <= 1'b1;
					if (r_free) free_q <= 1'b1;
				end
				ST_DECIDE: if (!hit_q && !table_full) occ_q <= occ_q + 1'b1;
				default: ;
			endcase
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IW-1:0];
		if (accept) begin
			fid_q <= s_tdata[31:0];
			ts_q  <= s_tdata[79:32];
			key_q <= key_in;
			t_q   <= t_in;
		end
		if (r_hit) begin
			hit_idx_q  <= rd_idx_s1;
			hit_last_q <= r_last;
			hit_s_q    <= $signed(mem_rdata[SW-1:0]);
		end
		if (r_free) free_idx_q <= rd_idx_s1;
		if (state_q == ST_DECIDE) begin
			d_q      <= t_x - hit_s_x;
			oldgap_q <= hit_last_x - hit_s_x;
			if (!hit_q) begin
				res_burst_q   <= table_full ? 1'b0 : burst_idle;
				res_outcome_q <= table_full ? OUT_DROPPED : OUT_NEW;
			end else begin
				res_burst_q   <= burst_idle;
				res_outcome_q <= OUT_RESTARTED;
			end
		end
		if (state_q == ST_MUL_LO) plo_q <= plo_d;
		if (state_q == ST_MUL_HI) phi_q <= phi_d;
		if (state_q == ST_SUM) snew_q <= SW'(snew_x);
		if (state_q == ST_UPDATE) begin
			res_burst_q   <= burst_upd;
			res_outcome_q <= OUT_UPDATED;
		end
		if (out_load) begin
			m_tdata_q <= {ts_q, fid_q};
			m_tuser_q <= {res_outcome_q, res_burst_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### hw/rtl/fbd_checker.sv
// Port-level checks of the flow burst detector, bound to the top level.
module fbd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [79:0]                    s_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [79:0]                    m_tdata,
	input logic [2:0]                     m_tuser,
	input logic                           psel,
	input logic                           penable,
	input logic                           pwrite,
	input logic [fbd_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [fbd_pkg::CFG_DATA_W-1:0] pwdata,
	input logic [fbd_pkg::CFG_DATA_W-1:0] prdata,
	input logic                           pready
);
	import fbd_pkg::*;

	// a dropped packet never reports a burst
	a_drop_no_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:1] == OUT_DROPPED |-> !m_tuser[0])
		else $error("burst on dropped packet");

	// one packet in work at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken during table scan");

	// a waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// config port never inserts wait states
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("config port stalled");

endmodule

bind flow_burst_detector_ewma_unit fbd_checker u_fbd_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the EWMA flow burst detector top level.
module testbench;
	import fbd_pkg::*;

	localparam int       FLOWS      = MAX_FLOWS_DEF;
	localparam longint   CYCLE_CAP  = 12_000_000;
	localparam bit [47:0] TIME_MAX  = 48'hFFFF_FFFF_FFFF;

	// one result item as the block reports it
	typedef struct {
		bit        burst;
		bit [31:0] flow;
		bit [47:0] stamp;
		outcome_t  outcome;
	} report_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [79:0]           s_tdata;   // flow_id[31:0], timestamp[79:32]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [79:0]           m_tdata;   // report_flow[31:0], report_time[79:32]
	logic [2:0]            m_tuser;   // burst[0], outcome[2:1]
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	flow_burst_detector_ewma_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow copy of the configuration registers
	bit [47:0] gap_lim;
	bit [47:0] idle_tmo;
	bit [47:0] flush_ivl;
	bit [15:0] weight;
	bit        flush_en;
	bit [10:0] tbl_limit;

	// shadow flow table
	bit        tbl_valid [FLOWS];
	bit        tbl_used  [FLOWS];
	bit [31:0] tbl_key   [FLOWS];
	longint    tbl_seen  [FLOWS];
	longint    tbl_smooth[FLOWS];
	int        tbl_count;
	longint    sweep_time;

	report_t   pending_reports[$];
	int        failures;
	longint    cycles;
	bit        steady;        // no random idling on either side while set
	int        hold_off;      // receiver stall, counted down in its own process
	bit [47:0] now_ticks;     // stimulus time base
	bit [31:0] flow_pool[$];

	always #1 clk = ~clk;

	initial begin
		clk = 0; arst_n = 0;
		s_tvalid = 0; s_tdata = '0; m_tready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		failures = 0; cycles = 0; steady = 0; hold_off = 0; now_ticks = 0;
	end

	// run length guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: random back-pressure, plus a long hold when asked
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 35);
		end
	end

	// floor of d / 2^16 for signed d
	function automatic longint floor_q16(longint d);
		if (d >= 0)
			return d / 65536;
		return -((-d + 65535) / 65536);
	endfunction

	function automatic longint ewma_step(longint s, longint t);
		longint m, d, hi, lo;
		m  = 65536 - longint'(weight);
		d  = t - s;
		hi = floor_q16(d);
		lo = d - hi * 65536;
		return s + hi * m + (lo * m) / 65536;
	endfunction

	// expected report for one packet; advances the shadow table
	function automatic report_t predict_report(bit [31:0] flow, bit [47:0] stamp);
		report_t r;
		longint  t, lim, idle, s, prior_gap;
		int      hit, free_slot, cap;
		t    = longint'(stamp);
		lim  = longint'(gap_lim);
		idle = longint'(idle_tmo);
		hit  = -1;
		free_slot = -1;
		r.burst = 0;
		r.flow  = flow;
		r.stamp = stamp;

		// sweep when the flush interval has run out
		if (t - sweep_time > longint'(flush_ivl)) begin
			if (flush_en) begin
				for (int i = 0; i < FLOWS; i++) begin
					if (!tbl_valid[i])
						continue;
					if (!tbl_used[i] || tbl_seen[i] + idle < t) begin
						tbl_valid[i] = 0;
						if (tbl_count > 0)
							tbl_count--;
					end
					tbl_used[i] = 0;
				end
			end
			sweep_time = t;
		end

		for (int i = 0; i < FLOWS; i++) begin
			if (tbl_valid[i]) begin
				if (hit < 0 && tbl_key[i] == flow)
					hit = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		cap = (tbl_limit > FLOWS) ? FLOWS : int'(tbl_limit);

		if (hit < 0) begin
			if (tbl_count >= cap || free_slot < 0) begin
				r.outcome = OUT_DROPPED;
			end else begin
				tbl_valid[free_slot]  = 1;
				tbl_used[free_slot]   = 1;
				tbl_key[free_slot]    = flow;
				tbl_seen[free_slot]   = t;
				tbl_smooth[free_slot] = t - idle;
				tbl_count++;
				r.burst   = idle < lim;
				r.outcome = OUT_NEW;
			end
		end else begin
			tbl_used[hit] = 1;
			if (tbl_seen[hit] + idle < t) begin
				// idle flow starts over
				tbl_seen[hit]   = t;
				tbl_smooth[hit] = t - idle;
				r.burst   = idle < lim;
				r.outcome = OUT_RESTARTED;
			end else begin
				prior_gap       = tbl_seen[hit] - tbl_smooth[hit];
				s               = ewma_step(tbl_smooth[hit], t);
				tbl_smooth[hit] = s;
				tbl_seen[hit]   = t;
				r.burst   = prior_gap >= lim && t - s < lim;
				r.outcome = OUT_UPDATED;
			end
		end
		return r;
	endfunction

	// one APB write; the shadow register follows at the access edge
	task automatic write_reg(reg_idx_t idx, bit [63:0] value);
		@(negedge clk);
		psel = 1; penable = 0; pwrite = 1;
		paddr = CFG_ADDR_W'(idx) << 3;
		pwdata = value;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		case (idx)
			REG_GAP_LIMIT:        gap_lim   = value[47:0];
			REG_IDLE_TIMEOUT:     idle_tmo  = value[47:0];
			REG_FLUSH_INTERVAL:   flush_ivl = value[47:0];
			REG_SMOOTHING_WEIGHT: weight    = value[15:0];
			REG_FLUSH_ENABLE:     flush_en  = value[0];
			REG_TABLE_LIMIT:      tbl_limit = value[10:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	// stop offering, all results in, then a short pause before touching the registers
	task automatic drain();
		@(negedge clk);
		s_tvalid = 0;
		wait (pending_reports.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_config(bit [47:0] gap, bit [47:0] idle, bit [47:0] ivl,
			bit [15:0] w, bit en, bit [10:0] lim);
		drain();
		write_reg(REG_GAP_LIMIT, gap);
		write_reg(REG_IDLE_TIMEOUT, idle);
		write_reg(REG_FLUSH_INTERVAL, ivl);
		write_reg(REG_SMOOTHING_WEIGHT, w);
		write_reg(REG_FLUSH_ENABLE, en);
		write_reg(REG_TABLE_LIMIT, lim);
	endtask

	// offer one packet item and hold it until accepted
	task automatic send_packet(bit [31:0] flow, bit [47:0] stamp);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 35) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tdata  = {stamp, flow};
		do
			@(posedge clk);
		while (!s_tready);
		pending_reports = {pending_reports, predict_report(flow, stamp)};
	endtask

	// compare every accepted result item with the oldest expectation
	always @(posedge clk) begin
		report_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected report flow=%h time=%h user=%b",
					$time, m_tdata[31:0], m_tdata[79:32], m_tuser);
				failures++;
			end else begin
				exp_r = pending_reports.pop_front();
				if (m_tdata[31:0] !== exp_r.flow) begin
					$display("%0t: report_flow expected %h actual %h",
						$time, exp_r.flow, m_tdata[31:0]);
					failures++;
				end
				if (m_tdata[79:32] !== exp_r.stamp) begin
					$display("%0t: report_time expected %h actual %h",
						$time, exp_r.stamp, m_tdata[79:32]);
					failures++;
				end
				if (m_tuser[0] !== exp_r.burst) begin
					$display("%0t: burst expected %b actual %b flow %h",
						$time, exp_r.burst, m_tuser[0], exp_r.flow);
					failures++;
				end
				if (m_tuser[2:1] !== exp_r.outcome) begin
					$display("%0t: outcome expected %s actual %0d flow %h",
						$time, exp_r.outcome.name(), m_tuser[2:1], exp_r.flow);
					failures++;
				end
			end
		end
	end

	task automatic fill_pool(int n);
		flow_pool.delete();
		repeat (n) flow_pool = {flow_pool, $urandom};
	endtask

	// random packets: mostly flows from a small pool with short gaps,
	// now and then long silences, strangers and steps back in time
	task automatic random_packets(int n, int pool_size);
		int        pick;
		bit [31:0] flow;
		bit [47:0] step;
		fill_pool(pool_size);
		repeat (n) begin
			flow = ($urandom_range(99) < 10) ? $urandom
				: flow_pool[$urandom_range(flow_pool.size() - 1)];
			pick = $urandom_range(99);
			if (pick < 70)
				step = 48'($urandom_range(400_000));
			else if (pick < 90)
				step = 48'($urandom_range(3_000_000));
			else if (pick < 97)
				step = 48'($urandom_range(150_000_000));
			else
				step = 0;
			if (pick >= 97 && now_ticks > 500_000)
				now_ticks = now_ticks - 48'($urandom_range(500_000));
			else
				now_ticks = now_ticks + step;
			send_packet(flow, now_ticks);
		end
	endtask

	// --- test tasks ---

	task automatic test_directed();
		send_packet(32'h0000_0000, 48'd0);             // first flow, time zero
		send_packet(32'hFFFF_FFFF, 48'd10);            // all-ones flow id
		send_packet(32'h0000_0000, 48'd20);            // plain EWMA update
		send_packet(32'h0000_0000, 48'd50_000);
		send_packet(32'hFFFF_FFFF, 48'd250_000_000);   // idle past timeout: the sweep evicts it, new entry
		send_packet(32'h0000_0000, 48'd250_000_100);   // evicted by the sweep: new entry
		send_packet(32'h0000_0000, 48'd100);           // timestamp goes backwards
		for (int i = 0; i < 12; i++)                   // fast stream drives the gap down
			send_packet(32'h1234_5678, 48'd250_100_000 + 48'(i) * 1000);
		now_ticks = 48'd250_200_000;
	endtask

	task automatic test_back_pressure();
		// receiver stalls long while the sender keeps offering
		steady = 1;
		hold_off = 6000;
		random_packets(30, 6);
		steady = 0;
		random_packets(370, 12);
	endtask

	task automatic test_small_table();
		set_config(48'd2_000_000, 48'd20_000_000, 48'd500_000, 16'h8000, 1'b0, 11'd3);
		random_packets(250, 10);
	endtask

	task automatic test_zero_weight();
		set_config(48'd1_500_000, 48'd1_000_000, 48'd80_000_000, 16'd0, 1'b1, 11'd16);
		random_packets(250, 20);
	endtask

	task automatic test_extremes();
		// never below gap, no idle allowance, sweep at every packet that moves time on
		set_config(TIME_MAX, 48'd0, 48'd0, 16'hFFFF, 1'b1, 11'h7FF);
		random_packets(100, 8);
		// reversed extremes
		set_config(48'd0, TIME_MAX, TIME_MAX, 16'd0, 1'b0, 11'd1024);
		random_packets(60, 8);
		// a zero limit drops every new flow
		set_config(48'd5_000_000, 48'd100_000_000, 48'd1_000_000, 16'd58982, 1'b1, 11'd0);
		random_packets(40, 4);
		send_packet(32'hA5A5_5A5A, TIME_MAX);
		send_packet(32'h5A5A_A5A5, TIME_MAX);
	endtask

	initial begin
		gap_lim = 48'd5_000_000; idle_tmo = 48'd100_000_000; flush_ivl = 48'd1_000_000;
		weight = 16'd58982; flush_en = 1; tbl_limit = 11'd1024;
		foreach (tbl_valid[i]) begin
			tbl_valid[i] = 0;
			tbl_used[i]  = 0;
		end
		tbl_count = 0;
		sweep_time = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_directed();
		test_back_pressure();
		test_small_table();
		test_zero_weight();
		test_extremes();

		@(negedge clk);
		s_tvalid = 0;
		wait (pending_reports.size() == 0);
		repeat (FLOWS + 50) @(posedge clk);
		if (failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
